/* rtl/core/eewtc_pkg.sv */
// Shared types and constants of the EEPROM write timing controller.
package eewtc_pkg;

	localparam int unsigned MEM_DEPTH_DEFAULT = 1024;
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned DC_W = 16;
	localparam int unsigned RATIO_W = 24;
	localparam int unsigned CYC_W = 20;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned PROD_W = RATIO_W + DC_W;
	localparam int unsigned WHOLE_W = PROD_W - FRAC_W;
	localparam int unsigned WIN_W = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [7:0] ERASED_BYTE = 8'hFF;
	localparam logic [WIN_W-1:0] WINDOW_CYCLES = 3'd4;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 24'd65536;
	localparam logic [CYC_W-1:0] ERASE_WRITE_RESET = 20'd3400;
	localparam logic [CYC_W-1:0] ERASE_RESET = 20'd1800;
	localparam logic [CYC_W-1:0] WRITE_ONLY_RESET = 20'd1800;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_ENABLE,
		OP_START,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		MODE_ERASE_WRITE,
		MODE_ERASE,
		MODE_WRITE_ONLY,
		MODE_RESERVED
	} mode_t;

	typedef enum logic [1:0] {
		REG_CLOCK_RATIO,
		REG_ERASE_WRITE,
		REG_ERASE,
		REG_WRITE_ONLY
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		op_t operation;
		logic [ADDR_W-1:0] address;
		logic [7:0] write_data;
		mode_t program_mode;
		logic interrupt_enable;
		logic spm_busy;
		logic [DC_W-1:0] elapsed_cycles;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic read_valid;
		logic write_busy;
		logic master_enable;
		logic ready_interrupt;
		logic device_busy;
	} rsp_t;

endpackage

/* rtl/core/eewtc_store.sv */
// Byte store with one write port and one registered read port.
module eewtc_store import eewtc_pkg::*; #(
	parameter int unsigned DEPTH = MEM_DEPTH_DEFAULT
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_idx,
	input logic [7:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_idx,
	output logic [7:0] rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

/* rtl/core/eeprom_write_timing_controller_core.sv */
// Top level of the EEPROM write timing controller.
//
//   Channel  Direction  Handshake          Payload
//   cmd      in         cmd_valid/stall    cmd_t (operation and operands)
//   rsp      out        rsp_valid/stall    rsp_t (read byte and status flags)
//   cfg      in         cfg_valid/ready    cfg_index, cfg_data
//
// Each command is handled in an accept step, which multiplies the clock ratio and issues
// the store read, and then an update step, which updates the counters and flags and
// writes the store. After reset the store is swept to 0xFF, one byte per cycle, over
// all MEM_DEPTH bytes before the first command is taken. A stalled response holds the
// update step; the next command is taken while a finished response waits.
module eeprom_write_timing_controller_core import eewtc_pkg::*; #(
	parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input cmd_t cmd,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input cfg_reg_t cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned IDX_W = $clog2(MEM_DEPTH);
	localparam int unsigned RANGE_W = ADDR_W + 1;

	state_t state_q, state_d;
	logic accept, done, clr_wr;
	logic [IDX_W-1:0] clr_q;

	cmd_t cmd_s1;
	logic [PROD_W-1:0] prod_s1;

	logic [RATIO_W-1:0] ratio_q;
	logic [CYC_W-1:0] ew_cyc_q, er_cyc_q, wo_cyc_q;

	logic [FRAC_W-1:0] frac_q, frac_d;
	logic [CYC_W-1:0] wait_q, wait_d;
	logic wait_act_q, wait_act_d;
	logic [7:0] pend_data_q, pend_data_d;
	logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
	logic pend_hit_q, pend_hit_d;
	mode_t pend_mode_q, pend_mode_d;
	logic busy_q, busy_d;
	logic enable_q, enable_d;
	logic [WIN_W-1:0] win_cnt_q, win_cnt_d;
	logic win_open_q, win_open_d;
	logic win_lock_q, win_lock_d;

	rsp_t rsp_q, rsp_d;
	logic rsp_valid_q;

	logic cmd_hit, cmd_s1_hit, exec_wr;
	logic [PROD_W-1:0] acc;
	logic [WHOLE_W-1:0] whole;
	logic wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0] wr_data, rd_data;

	assign cfg_ready = 1'b1;
	assign cmd_hit = {1'b0, cmd.address} < RANGE_W'(MEM_DEPTH);
	assign cmd_s1_hit = {1'b0, cmd_s1.address} < RANGE_W'(MEM_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_stall = 1'b1;
		accept = 1'b0;
		done = 1'b0;
		clr_wr = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				clr_wr = 1'b1;
				if (clr_q == IDX_W'(MEM_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					accept = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!rsp_valid_q || !rsp_stall) begin
					done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
			ew_cyc_q <= ERASE_WRITE_RESET;
			er_cyc_q <= ERASE_RESET;
			wo_cyc_q <= WRITE_ONLY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CLOCK_RATIO: ratio_q <= cfg_data[RATIO_W-1:0];
				REG_ERASE_WRITE: ew_cyc_q <= cfg_data[CYC_W-1:0];
				REG_ERASE: er_cyc_q <= cfg_data[CYC_W-1:0];
				REG_WRITE_ONLY: wo_cyc_q <= cfg_data[CYC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			prod_s1 <= PROD_W'(ratio_q) * PROD_W'(cmd.elapsed_cycles);
		end
	end

	assign acc = PROD_W'(frac_q) + prod_s1;
	assign whole = acc[PROD_W-1:FRAC_W];

	always_comb begin
		frac_d = frac_q;
		wait_d = wait_q;
		wait_act_d = wait_act_q;
		pend_data_d = pend_data_q;
		pend_idx_d = pend_idx_q;
		pend_hit_d = pend_hit_q;
		pend_mode_d = pend_mode_q;
		busy_d = busy_q;
		enable_d = enable_q;
		win_cnt_d = win_cnt_q;
		win_open_d = win_open_q;
		win_lock_d = win_lock_q;
		exec_wr = 1'b0;
		rsp_d = '0;
		unique case (cmd_s1.operation)
			OP_TICK: begin
				frac_d = acc[FRAC_W-1:0];
				if (win_open_q && !win_lock_q) begin
					win_cnt_d = (DC_W'(win_cnt_q) > cmd_s1.elapsed_cycles) ?
						win_cnt_q - cmd_s1.elapsed_cycles[WIN_W-1:0] : '0;
				end
				if (win_cnt_d == '0) begin
					enable_d = 1'b0;
					win_open_d = 1'b0;
				end
				if (wait_act_q) begin
					if (WHOLE_W'(wait_q) <= whole) begin
						exec_wr = pend_hit_q && (pend_mode_q == MODE_ERASE_WRITE ||
							pend_mode_q == MODE_ERASE);
						busy_d = 1'b0;
						wait_act_d = 1'b0;
						wait_d = '0;
					end else begin
						wait_d = wait_q - whole[CYC_W-1:0];
					end
				end
				win_lock_d = 1'b0;
			end
			OP_ENABLE: begin
				win_cnt_d = WINDOW_CYCLES;
				win_open_d = 1'b1;
				win_lock_d = 1'b1;
				enable_d = 1'b1;
			end
			OP_START: begin
				if (cmd_s1.spm_busy || !win_open_q) begin
					busy_d = 1'b0;
				end else begin
					busy_d = 1'b1;
					pend_mode_d = cmd_s1.program_mode;
					pend_idx_d = cmd_s1.address[IDX_W-1:0];
					pend_hit_d = cmd_s1_hit;
					pend_data_d = cmd_s1.write_data;
					wait_act_d = 1'b1;
					unique case (cmd_s1.program_mode)
						MODE_ERASE_WRITE: wait_d = ew_cyc_q;
						MODE_ERASE: wait_d = er_cyc_q;
						MODE_WRITE_ONLY: wait_d = wo_cyc_q;
						default: begin
							wait_d = '0;
							wait_act_d = 1'b0;
						end
					endcase
				end
			end
			OP_READ: begin
				if (!busy_q && cmd_s1_hit) begin
					rsp_d.read_data = rd_data;
					rsp_d.read_valid = 1'b1;
				end
			end
			default: ;
		endcase
		rsp_d.write_busy = busy_d;
		rsp_d.master_enable = enable_d;
		rsp_d.ready_interrupt = cmd_s1.interrupt_enable && !busy_d;
		rsp_d.device_busy = busy_d || cmd_s1.interrupt_enable || win_open_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= '0;
			wait_q <= '0;
			wait_act_q <= 1'b0;
			pend_data_q <= '0;
			pend_idx_q <= '0;
			pend_hit_q <= 1'b0;
			pend_mode_q <= MODE_ERASE_WRITE;
			busy_q <= 1'b0;
			enable_q <= 1'b0;
			win_cnt_q <= '0;
			win_open_q <= 1'b0;
			win_lock_q <= 1'b0;
		end else if (done) begin
			frac_q <= frac_d;
			wait_q <= wait_d;
			wait_act_q <= wait_act_d;
			pend_data_q <= pend_data_d;
			pend_idx_q <= pend_idx_d;
			pend_hit_q <= pend_hit_d;
			pend_mode_q <= pend_mode_d;
			busy_q <= busy_d;
			enable_q <= enable_d;
			win_cnt_q <= win_cnt_d;
			win_open_q <= win_open_d;
			win_lock_q <= win_lock_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign wr_en = clr_wr || (done && exec_wr);
	assign wr_idx = clr_wr ? clr_q : pend_idx_q;
	assign wr_data = (clr_wr || pend_mode_q != MODE_ERASE_WRITE) ? ERASED_BYTE : pend_data_q;

	eewtc_store #(
		.DEPTH(MEM_DEPTH)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.wr_data(wr_data),
		.rd_en(accept && cmd_hit),
		.rd_idx(cmd.address[IDX_W-1:0]),
		.rd_data(rd_data)
	);

`ifndef SYNTH
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> state_q == ST_EXEC)
		else $error("Accepted command did not enter the update step.");

	a_lock_window: assert property (@(posedge clk) disable iff (!arst_n)
		win_lock_q |-> win_open_q && win_cnt_q == WINDOW_CYCLES)
		else $error("Locked window is not open at full length.");

	a_wait_mode: assert property (@(posedge clk) disable iff (!arst_n)
		wait_act_q |-> pend_mode_q != MODE_RESERVED)
		else $error("Countdown runs for the reserved mode.");

	a_write_tick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC && wr_en |-> cmd_s1.operation == OP_TICK)
		else $error("Store written by a command other than a tick.");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !rsp_valid_q && cmd_stall)
		else $error("Transfer activity during the clearing sweep.");
`endif

endmodule

/* bench/eeprom_write_timing_controller_core_tb.sv */
// Self-checking testbench for the EEPROM write timing controller core.
`timescale 1ns / 100ps

module eeprom_write_timing_controller_core_tb import eewtc_pkg::*; ();

	localparam int unsigned DEPTH = MEM_DEPTH_DEFAULT;
	localparam int unsigned DEPTH_W = $clog2(DEPTH);

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_CLOCK_RATIO;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	eeprom_write_timing_controller_core #(
		.MEM_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [RATIO_W-1:0] ratio_q;
	logic [CYC_W-1:0] erase_write_q;
	logic [CYC_W-1:0] erase_q;
	logic [CYC_W-1:0] write_only_q;
	logic [7:0] bytes_q [DEPTH];
	logic [15:0] frac_q;
	logic [31:0] countdown_q;
	logic countdown_on;
	logic [7:0] held_data;
	logic [15:0] held_addr;
	mode_t held_mode;
	logic busy_q;
	logic enable_q;
	logic [31:0] window_left;
	logic window_on;
	logic window_frozen;

	rsp_t expected_status [$];
	rsp_t want;
	int mismatches = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	function automatic rsp_t controller_step(input cmd_t c);
		rsp_t r;
		logic [63:0] acc;
		logic [31:0] whole;
		r = '0;
		case (c.operation)
			OP_TICK: begin
				acc = {48'd0, frac_q} + {40'd0, ratio_q} * {48'd0, c.elapsed_cycles};
				whole = acc[47:16];
				frac_q = acc[15:0];
				if (window_on && !window_frozen) begin
					if (window_left > {16'd0, c.elapsed_cycles})
						window_left = window_left - {16'd0, c.elapsed_cycles};
					else
						window_left = '0;
				end
				if (window_left == 0) begin
					enable_q = 1'b0;
					window_on = 1'b0;
				end
				if (countdown_on) begin
					if (whole >= countdown_q) begin
						if (held_addr < DEPTH) begin
							if (held_mode == MODE_ERASE_WRITE)
								bytes_q[held_addr[DEPTH_W-1:0]] = held_data;
							else if (held_mode == MODE_ERASE)
								bytes_q[held_addr[DEPTH_W-1:0]] = ERASED_BYTE;
						end
						busy_q = 1'b0;
						countdown_on = 1'b0;
						countdown_q = '0;
					end else begin
						countdown_q = countdown_q - whole;
					end
				end
				window_frozen = 1'b0;
			end
			OP_ENABLE: begin
				window_left = {29'd0, WINDOW_CYCLES};
				window_on = 1'b1;
				window_frozen = 1'b1;
				enable_q = 1'b1;
			end
			OP_START: begin
				if (c.spm_busy || !window_on) begin
					busy_q = 1'b0;
				end else begin
					busy_q = 1'b1;
					held_mode = c.program_mode;
					held_addr = c.address;
					held_data = c.write_data;
					countdown_on = 1'b1;
					case (c.program_mode)
						MODE_ERASE_WRITE: countdown_q = {12'd0, erase_write_q};
						MODE_ERASE: countdown_q = {12'd0, erase_q};
						MODE_WRITE_ONLY: countdown_q = {12'd0, write_only_q};
						default: begin
							countdown_q = '0;
							countdown_on = 1'b0;
						end
					endcase
				end
			end
			default: begin
				if (!busy_q && c.address < DEPTH) begin
					r.read_data = bytes_q[c.address[DEPTH_W-1:0]];
					r.read_valid = 1'b1;
				end
			end
		endcase
		r.write_busy = busy_q;
		r.master_enable = enable_q;
		r.ready_interrupt = c.interrupt_enable && !busy_q;
		r.device_busy = busy_q || c.interrupt_enable || window_on;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_val,
			input logic [7:0] got_val);
		if (exp_val !== got_val) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch on %s: expected %0h, got %0h at %0t", name, exp_val,
					got_val, $realtime);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall) begin
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Response transfer with nothing expected at %0t", $realtime);
			end else begin
				want = expected_status.pop_front();
				check_field("read_data", want.read_data, rsp.read_data);
				check_field("read_valid", {7'd0, want.read_valid}, {7'd0, rsp.read_valid});
				check_field("write_busy", {7'd0, want.write_busy}, {7'd0, rsp.write_busy});
				check_field("master_enable", {7'd0, want.master_enable},
					{7'd0, rsp.master_enable});
				check_field("ready_interrupt", {7'd0, want.ready_interrupt},
					{7'd0, rsp.ready_interrupt});
				check_field("device_busy", {7'd0, want.device_busy}, {7'd0, rsp.device_busy});
			end
		end
	end

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_cmd(input cmd_t c);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		expected_status.push_back(controller_step(c));
		items_sent++;
	endtask

	task automatic settle_block();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_CLOCK_RATIO: ratio_q = val;
			REG_ERASE_WRITE: erase_write_q = val[CYC_W-1:0];
			REG_ERASE: erase_q = val[CYC_W-1:0];
			default: write_only_q = val[CYC_W-1:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_timing(input logic [23:0] ratio, input logic [23:0] ew,
			input logic [23:0] er, input logic [23:0] wo);
		settle_block();
		write_reg(REG_CLOCK_RATIO, ratio);
		write_reg(REG_ERASE_WRITE, ew);
		write_reg(REG_ERASE, er);
		write_reg(REG_WRITE_ONLY, wo);
	endtask

	function automatic cmd_t op_cmd(input op_t op, input logic [15:0] addr,
			input logic [7:0] data, input mode_t mode, input logic ie, input logic spm,
			input logic [15:0] dc);
		cmd_t c;
		c.operation = op;
		c.address = addr;
		c.write_data = data;
		c.program_mode = mode;
		c.interrupt_enable = ie;
		c.spm_busy = spm;
		c.elapsed_cycles = dc;
		return c;
	endfunction

	function automatic cmd_t random_cmd(input op_t op, input int tick_span);
		cmd_t c;
		int pick;
		pick = $urandom_range(99);
		c.operation = op;
		if (pick < 70)
			c.address = 16'($urandom_range(31));
		else if (pick < 90)
			c.address = 16'($urandom_range(DEPTH - 1));
		else
			c.address = 16'($urandom_range(16'hFFFF));
		c.write_data = 8'($urandom_range(255));
		c.program_mode = ($urandom_range(9) == 0) ? MODE_RESERVED
			: mode_t'($urandom_range(2));
		c.interrupt_enable = 1'($urandom_range(1));
		c.spm_busy = ($urandom_range(9) == 0);
		c.elapsed_cycles = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFF))
			: 16'($urandom_range(tick_span));
		return c;
	endfunction

	// Mostly complete enable, start and countdown sequences; the rest is loose noise.
	task automatic random_traffic(input int count, input int tick_span);
		int stop_at;
		int steps;
		cmd_t start_item;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 75) begin
				send_cmd(random_cmd(OP_ENABLE, tick_span));
				if ($urandom_range(1) == 1)
					send_cmd(random_cmd(OP_TICK, tick_span));
				start_item = random_cmd(OP_START, tick_span);
				if ($urandom_range(3) != 0)
					start_item.spm_busy = 1'b0;
				send_cmd(start_item);
				steps = $urandom_range(6, 1);
				repeat (steps) begin
					if ($urandom_range(99) < 70)
						send_cmd(random_cmd(OP_TICK, tick_span));
					else
						send_cmd(random_cmd(OP_READ, tick_span));
				end
				start_item.operation = OP_READ;
				send_cmd(start_item);
			end else begin
				send_cmd(random_cmd(op_t'($urandom_range(3)), tick_span));
			end
		end
	endtask

	task automatic test_default_timing();
		send_idle_pct = 28;
		recv_idle_pct = 71;
		send_cmd(op_cmd(OP_READ, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_READ, 16'd1024, 8'h00, MODE_ERASE_WRITE, 1'b1, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_READ, 16'hFFFF, 8'hFF, MODE_RESERVED, 1'b1, 1'b1, 16'hFFFF));
		send_cmd(op_cmd(OP_START, 16'd3, 8'hA5, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_ENABLE, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b1, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_TICK, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd3));
		send_cmd(op_cmd(OP_START, 16'd3, 8'hA5, MODE_ERASE_WRITE, 1'b0, 1'b1, 16'd0));
		send_cmd(op_cmd(OP_START, 16'd3, 8'hA5, MODE_ERASE_WRITE, 1'b1, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_READ, 16'd3, 8'h00, MODE_ERASE_WRITE, 1'b1, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_TICK, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'hFFFF));
		send_cmd(op_cmd(OP_READ, 16'd3, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_ENABLE, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_START, 16'd3, 8'h00, MODE_ERASE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_START, 16'd4, 8'h77, MODE_WRITE_ONLY, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_TICK, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b1, 1'b0, 16'hFFFF));
		send_cmd(op_cmd(OP_READ, 16'd3, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_ENABLE, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_START, 16'd3, 8'h11, MODE_RESERVED, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_TICK, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'hFFFF));
		send_cmd(op_cmd(OP_READ, 16'd3, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_START, 16'd3, 8'h11, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_ENABLE, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_START, 16'd1023, 8'h5A, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_START, 16'd1023, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b1, 16'd0));
		send_cmd(op_cmd(OP_TICK, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'hFFFF));
		send_cmd(op_cmd(OP_READ, 16'd1023, 8'h00, MODE_ERASE_WRITE, 1'b1, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_ENABLE, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_START, 16'hFFFF, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'd0));
		send_cmd(op_cmd(OP_TICK, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0, 1'b0, 16'hFFFF));
	endtask

	task automatic test_traffic_slow_receiver();
		send_idle_pct = 28;
		recv_idle_pct = 71;
		set_timing(24'h010000, 24'($urandom_range(48, 1)), 24'($urandom_range(48, 1)),
			24'($urandom_range(48, 1)));
		random_traffic(320, 24);
	endtask

	task automatic test_traffic_slow_sender();
		send_idle_pct = 71;
		recv_idle_pct = 28;
		set_timing(24'($urandom_range(262143, 16384)), 24'($urandom_range(100, 1)),
			24'($urandom_range(100, 1)), 24'($urandom_range(100, 1)));
		random_traffic(320, 40);
	endtask

	task automatic test_timing_extremes();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_timing(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		random_traffic(50, 64);
		// Zero cycle counts expire on the first tick, even with a zero ratio.
		set_timing(24'h000000, 24'h000000, 24'h000000, 24'h000000);
		random_traffic(50, 64);
		set_timing(24'h000001, 24'h000001, 24'h000001, 24'h000001);
		random_traffic(50, 64);
	endtask

	task automatic test_full_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_timing(24'h010000, 24'd8, 24'd8, 24'd8);
		hold_request = 400;
		random_traffic(120, 16);
		settle_block();
	endtask

	initial begin
		ratio_q = RATIO_RESET;
		erase_write_q = ERASE_WRITE_RESET;
		erase_q = ERASE_RESET;
		write_only_q = WRITE_ONLY_RESET;
		foreach (bytes_q[i])
			bytes_q[i] = ERASED_BYTE;
		frac_q = '0;
		countdown_q = '0;
		countdown_on = 1'b0;
		held_data = '0;
		held_addr = '0;
		held_mode = MODE_ERASE_WRITE;
		busy_q = 1'b0;
		enable_q = 1'b0;
		window_left = '0;
		window_on = 1'b0;
		window_frozen = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_timing();
		test_traffic_slow_receiver();
		test_traffic_slow_sender();
		test_timing_extremes();
		test_full_backpressure();

		settle_block();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_status.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/eewtc_pkg.sv
rtl/core/eewtc_store.sv
rtl/core/eeprom_write_timing_controller_core.sv
bench/eeprom_write_timing_controller_core_tb.sv
